// ===== sv/lrse_pkg.sv =====
// Shared types, codes and default sizes of the LR shift-reduce engine.
package lrse_pkg;

    // Default table and stack sizes.
    localparam int LRSE_STATE_COUNT     = 256;
    localparam int LRSE_SYMBOL_COUNT    = 128;
    localparam int LRSE_RULE_COUNT      = 256;
    localparam int LRSE_STACK_DEPTH     = 64;
    localparam int LRSE_MAX_RULE_LENGTH = 15;

    // Reductions allowed in a row before the run is declared an error.
    localparam logic [5:0] RUN_LIMIT = 6'd63;

    // Input word modes.
    localparam logic [1:0] MODE_TOKEN       = 2'd0;
    localparam logic [1:0] MODE_LOAD_ACTION = 2'd1;
    localparam logic [1:0] MODE_LOAD_RULE   = 2'd2;

    // Action table entry kinds.
    localparam logic [2:0] KIND_ERROR  = 3'd0;
    localparam logic [2:0] KIND_SHIFT  = 3'd1;
    localparam logic [2:0] KIND_REDUCE = 3'd2;
    localparam logic [2:0] KIND_ACCEPT = 3'd3;
    localparam logic [2:0] KIND_GOTO   = 3'd4;

    // Result event codes.
    localparam logic [2:0] EV_SHIFT  = 3'd0;
    localparam logic [2:0] EV_REDUCE = 3'd1;
    localparam logic [2:0] EV_ACCEPT = 3'd2;
    localparam logic [2:0] EV_ERROR  = 3'd3;
    localparam logic [2:0] EV_LOAD   = 3'd4;

    // Input word.
    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] symbol;
        logic [7:0] row_state;
        logic [2:0] action_kind;
        logic [7:0] action_target;
        logic [7:0] rule_id;
        logic [3:0] rule_length;
        logic [6:0] rule_left;
    } lrse_in_t;

    // Result word.
    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] reduced_rule;
        logic [7:0] new_top;
        logic [6:0] stack_level;
        logic       last;
    } lrse_out_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACT_RD,
        ST_ACT_EVAL,
        ST_RULE_EVAL,
        ST_STK_EVAL,
        ST_GOTO_EVAL,
        ST_ERROR,
        ST_LOAD
    } lrse_state_t;

endpackage

// ===== sv/lrse_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
module lrse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; the read data holds between reads.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/lr_shift_reduce_engine_unit.sv =====
// Top level of the table-driven LR shift-reduce engine.
//
// Input words arrive on s_valid/s_ready/s_data, results leave on
// m_valid/m_ready/m_data. A word of mode 1 or 2 writes one action/goto or
// rule table entry and gives one load-done result.
// A token word is looked up against the state on top of the stack: every
// reduction gives one result (last low) after the action, rule, stack and
// goto memory reads, done in turn on the shared sequencer; the closing
// shift, accept or error result (last high) ends the run. A token that
// shifts at once gives its result after the action read and its check.
// One word is in work at a time: s_ready is high only while the sequencer
// is idle, and it may be high while the previous result still waits.
// When the receiver stalls, a step that gives a result holds until
// the output register is free, so no result is lost or repeated.
// Reset (aresetn low at a clock edge) empties the stack to the start state
// 0 and clears the reduction count; table contents are kept, and entries
// never written read back as anything. No clearing pass is needed.
module lr_shift_reduce_engine_unit #(
    parameter int STATE_COUNT     = lrse_pkg::LRSE_STATE_COUNT,
    parameter int SYMBOL_COUNT    = lrse_pkg::LRSE_SYMBOL_COUNT,
    parameter int RULE_COUNT      = lrse_pkg::LRSE_RULE_COUNT,
    parameter int STACK_DEPTH     = lrse_pkg::LRSE_STACK_DEPTH,
    parameter int MAX_RULE_LENGTH = lrse_pkg::LRSE_MAX_RULE_LENGTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lrse_pkg::lrse_in_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lrse_pkg::lrse_out_t m_data
);

    import lrse_pkg::*;

    // Sizes reachable through the 8-bit state and 7-bit symbol fields.
    localparam int ST_EFF   = (STATE_COUNT > 256) ? 256 : STATE_COUNT;
    localparam int SY_EFF   = (SYMBOL_COUNT > 128) ? 128 : SYMBOL_COUNT;
    localparam int RULE_EFF = (RULE_COUNT > 256) ? 256 : RULE_COUNT;
    localparam int ACT_DEPTH = ST_EFF * SY_EFF;
    localparam int AAW = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
    localparam int RAW = (RULE_EFF > 1) ? $clog2(RULE_EFF) : 1;
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    // Control registers.
    lrse_state_t    state_reg, state_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [7:0]     top_reg, top_next;
    logic [5:0]     run_reg, run_next;
    logic           m_valid_reg, m_valid_next;

    // Working registers of the current token.
    logic [6:0]     sym_reg, sym_next;
    logic           oor_reg, oor_next;
    logic [7:0]     rule_num_reg, rule_num_next;
    logic [6:0]     left_reg, left_next;
    logic [SPW-1:0] newsp_reg, newsp_next;
    logic           base_zero_reg, base_zero_next;
    lrse_out_t      m_data_reg, m_data_next;

    // Memory ports.
    logic           act_we, act_re;
    logic [AAW-1:0] act_waddr, act_raddr;
    logic [10:0]    act_wdata, act_rdata;
    logic           rule_we, rule_re;
    logic [RAW-1:0] rule_waddr, rule_raddr;
    logic [10:0]    rule_wdata, rule_rdata;
    logic           stk_we, stk_re;
    logic [SAW-1:0] stk_waddr, stk_raddr;
    logic [7:0]     stk_wdata, stk_rdata;

    // Decoded fields and helpers.
    logic           out_free;
    logic [2:0]     act_kind;
    logic [7:0]     act_tgt;
    logic [3:0]     rule_len;
    logic [SPW-1:0] newsp_calc;
    logic [7:0]     exposed;

    // Row-major index into the action/goto table.
    function automatic logic [AAW-1:0] act_index(input logic [7:0] row,
                                                 input logic [6:0] col);
        act_index = AAW'(row) * AAW'(SY_EFF) + AAW'(col);
    endfunction

    function automatic lrse_out_t make_res(input logic [2:0] ev,
                                           input logic [7:0] rule,
                                           input logic [7:0] top,
                                           input logic [SPW-1:0] level,
                                           input logic last);
        lrse_out_t r;
        r.event_res    = ev;
        r.reduced_rule = rule;
        r.new_top      = top;
        r.stack_level  = 7'(level);
        r.last         = last;
        make_res = r;
    endfunction

    // Action/goto table, rule table and state stack.
    lrse_ram #(.WIDTH(11), .DEPTH(ACT_DEPTH)) u_act_ram (
        .aclk    (aclk),
        .wr_en   (act_we),
        .wr_addr (act_waddr),
        .wr_data (act_wdata),
        .rd_en   (act_re),
        .rd_addr (act_raddr),
        .rd_data (act_rdata)
    );

    lrse_ram #(.WIDTH(11), .DEPTH(RULE_EFF)) u_rule_ram (
        .aclk    (aclk),
        .wr_en   (rule_we),
        .wr_addr (rule_waddr),
        .wr_data (rule_wdata),
        .rd_en   (rule_re),
        .rd_addr (rule_raddr),
        .rd_data (rule_rdata)
    );

    lrse_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_we),
        .wr_addr (stk_waddr),
        .wr_data (stk_wdata),
        .rd_en   (stk_re),
        .rd_addr (stk_raddr),
        .rd_data (stk_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign s_ready  = (state_reg == ST_IDLE);

    // Field decode of the memory read data; out-of-range lookups read as error.
    assign act_kind   = oor_reg ? KIND_ERROR : act_rdata[10:8];
    assign act_tgt    = act_rdata[7:0];
    assign rule_len   = rule_rdata[10:7];
    assign newsp_calc = sp_reg - SPW'(rule_len);
    // Stack entry zero is never written; a pop to it reads the start state 0.
    assign exposed    = base_zero_reg ? 8'd0 : stk_rdata;

    // Sequencer: next state, memory controls and result words.
    always_comb begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        top_next       = top_reg;
        run_next       = run_reg;
        sym_next       = sym_reg;
        oor_next       = oor_reg;
        rule_num_next  = rule_num_reg;
        left_next      = left_reg;
        newsp_next     = newsp_reg;
        base_zero_next = base_zero_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        act_we     = 1'b0;
        act_waddr  = act_index(s_data.row_state, s_data.symbol);
        act_wdata  = {s_data.action_kind, s_data.action_target};
        act_re     = 1'b0;
        act_raddr  = act_index(top_reg, sym_reg);
        rule_we    = 1'b0;
        rule_waddr = s_data.rule_id[RAW-1:0];
        rule_wdata = {s_data.rule_length, s_data.rule_left};
        rule_re    = 1'b0;
        rule_raddr = act_tgt[RAW-1:0];
        stk_we     = 1'b0;
        stk_waddr  = sp_reg[SAW-1:0];
        stk_wdata  = act_tgt;
        stk_re     = 1'b0;
        stk_raddr  = SAW'(newsp_calc - SPW'(1));

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sym_next = s_data.symbol;
                    unique case (s_data.mode)
                        MODE_TOKEN: begin
                            state_next = ST_ACT_RD;
                        end
                        MODE_LOAD_ACTION: begin
                            act_we = (32'(s_data.row_state) < ST_EFF)
                                  && (32'(s_data.symbol) < SY_EFF);
                            state_next = ST_LOAD;
                        end
                        MODE_LOAD_RULE: begin
                            rule_we    = 32'(s_data.rule_id) < RULE_EFF;
                            state_next = ST_LOAD;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Look the token up against the stack top.
            ST_ACT_RD: begin
                act_re     = 1'b1;
                oor_next   = (32'(top_reg) >= ST_EFF) || (32'(sym_reg) >= SY_EFF);
                state_next = ST_ACT_EVAL;
            end

            ST_ACT_EVAL: begin
                unique case (act_kind)
                    KIND_SHIFT: begin
                        if (32'(sp_reg) >= STACK_DEPTH) begin
                            state_next = ST_ERROR;
                        end else if (out_free) begin
                            stk_we       = 1'b1;
                            sp_next      = sp_reg + SPW'(1);
                            top_next     = act_tgt;
                            run_next     = '0;
                            m_valid_next = 1'b1;
                            m_data_next  = make_res(EV_SHIFT, 8'd0, act_tgt,
                                                    sp_reg + SPW'(1), 1'b1);
                            state_next   = ST_IDLE;
                        end
                    end
                    KIND_ACCEPT: begin
                        if (out_free) begin
                            sp_next      = SPW'(1);
                            top_next     = 8'd0;
                            run_next     = '0;
                            m_valid_next = 1'b1;
                            m_data_next  = make_res(EV_ACCEPT, 8'd0, 8'd0,
                                                    SPW'(1), 1'b1);
                            state_next   = ST_IDLE;
                        end
                    end
                    KIND_REDUCE: begin
                        if (run_reg >= RUN_LIMIT || 32'(act_tgt) >= RULE_EFF) begin
                            state_next = ST_ERROR;
                        end else begin
                            rule_re       = 1'b1;
                            rule_num_next = act_tgt;
                            state_next    = ST_RULE_EVAL;
                        end
                    end
                    default: begin
                        state_next = ST_ERROR;
                    end
                endcase
            end

            // Check the rule and read the state it exposes.
            ST_RULE_EVAL: begin
                if (32'(rule_len) > MAX_RULE_LENGTH || SPW'(rule_len) >= sp_reg) begin
                    state_next = ST_ERROR;
                end else begin
                    stk_re         = 1'b1;
                    newsp_next     = newsp_calc;
                    left_next      = rule_rdata[6:0];
                    base_zero_next = (newsp_calc == SPW'(1));
                    state_next     = ST_STK_EVAL;
                end
            end

            // Look up the goto entry of the exposed state.
            ST_STK_EVAL: begin
                act_re     = 1'b1;
                act_raddr  = act_index(exposed, left_reg);
                oor_next   = (32'(exposed) >= ST_EFF) || (32'(left_reg) >= SY_EFF);
                state_next = ST_GOTO_EVAL;
            end

            ST_GOTO_EVAL: begin
                if (act_kind != KIND_GOTO || 32'(newsp_reg) >= STACK_DEPTH) begin
                    state_next = ST_ERROR;
                end else if (out_free) begin
                    stk_we       = 1'b1;
                    stk_waddr    = newsp_reg[SAW-1:0];
                    sp_next      = newsp_reg + SPW'(1);
                    top_next     = act_tgt;
                    run_next     = run_reg + 6'd1;
                    m_valid_next = 1'b1;
                    m_data_next  = make_res(EV_REDUCE, rule_num_reg, act_tgt,
                                            newsp_reg + SPW'(1), 1'b0);
                    state_next   = ST_ACT_RD;
                end
            end

            // Error empties the stack back to the start state.
            ST_ERROR: begin
                if (out_free) begin
                    sp_next      = SPW'(1);
                    top_next     = 8'd0;
                    run_next     = '0;
                    m_valid_next = 1'b1;
                    m_data_next  = make_res(EV_ERROR, 8'd0, 8'd0, SPW'(1), 1'b1);
                    state_next   = ST_IDLE;
                end
            end

            ST_LOAD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = make_res(EV_LOAD, 8'd0, top_reg, sp_reg, 1'b1);
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sp_reg      <= SPW'(1);
            top_reg     <= 8'd0;
            run_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            top_reg     <= top_next;
            run_reg     <= run_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        sym_reg       <= sym_next;
        oor_reg       <= oor_next;
        rule_num_reg  <= rule_num_next;
        left_reg      <= left_next;
        newsp_reg     <= newsp_next;
        base_zero_reg <= base_zero_next;
        m_data_reg    <= m_data_next;
    end

    // The stack always holds at least the start state and never overflows.
    a_sp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (sp_reg != '0) && (32'(sp_reg) <= STACK_DEPTH))
        else $error("stack pointer out of range");

    // Only a reduction result may leave the run open.
    a_last_reduce: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> (m_data.event_res == EV_REDUCE))
        else $error("non-final result that is not a reduction");

    // Accept and error always report the emptied stack.
    a_reset_stack: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.event_res == EV_ERROR || m_data.event_res == EV_ACCEPT))
        |-> (m_data.new_top == 8'd0 && m_data.stack_level == 7'd1))
        else $error("accept or error result without an emptied stack");

    // A token word keeps the input closed while it is looked up.
    a_token_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.mode == MODE_TOKEN) |=> !s_ready)
        else $error("input open during a token lookup");

endmodule
